// File: sv/small_prime_exponent_factorizer_core_macros.svh
`ifndef SMALL_PRIME_EXPONENT_FACTORIZER_CORE_MACROS_SVH
`define SMALL_PRIME_EXPONENT_FACTORIZER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define SPEF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spef assertion failed");

// next-cycle implication, held off during reset
`define SPEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spef assertion failed");

`endif

// File: sv/spef_pkg.sv
package spef_pkg;

    localparam int INPUT_WIDTH_DEF = 31;
    localparam int PRIME_COUNT     = 11;
    localparam int PRIME_W         = 5;
    localparam int EXP_W           = 5;
    localparam int DIGIT_W         = 8;
    localparam int IDX_W           = $clog2(PRIME_COUNT);

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic load;
        logic start_div;
        logic div_step;
        logic commit;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic n_zero;
        logic divisible;
        logic last_prime;
    } t_dp_status;

    function automatic logic [PRIME_W-1:0] prime_of(input t_idx idx);
        logic [PRIME_W-1:0] p;
        case (idx)
            t_idx'(0):  p = PRIME_W'(2);
            t_idx'(1):  p = PRIME_W'(3);
            t_idx'(2):  p = PRIME_W'(5);
            t_idx'(3):  p = PRIME_W'(7);
            t_idx'(4):  p = PRIME_W'(11);
            t_idx'(5):  p = PRIME_W'(13);
            t_idx'(6):  p = PRIME_W'(17);
            t_idx'(7):  p = PRIME_W'(19);
            t_idx'(8):  p = PRIME_W'(23);
            t_idx'(9):  p = PRIME_W'(29);
            t_idx'(10): p = PRIME_W'(31);
            default:    p = PRIME_W'(31);
        endcase
        return p;
    endfunction

    // saturation point of each exponent field
    function automatic logic [EXP_W-1:0] exp_limit(input t_idx idx);
        logic [EXP_W-1:0] l;
        case (idx)
            t_idx'(0), t_idx'(1):                       l = EXP_W'(31);
            t_idx'(2), t_idx'(3), t_idx'(4), t_idx'(5): l = EXP_W'(15);
            default:                                    l = EXP_W'(7);
        endcase
        return l;
    endfunction

endpackage

// File: sv/spef_in_if.sv
interface spef_in_if #(
    parameter int INPUT_WIDTH = spef_pkg::INPUT_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [INPUT_WIDTH-1:0] n_value;

    modport source (output valid, output n_value, input ready);
    modport sink   (input valid, input n_value, output ready);
endinterface

// File: sv/spef_out_if.sv
interface spef_out_if ();
    logic       valid;
    logic       ready;
    logic [4:0] exp_2;
    logic [4:0] exp_3;
    logic [3:0] exp_5;
    logic [3:0] exp_7;
    logic [3:0] exp_11;
    logic [3:0] exp_13;
    logic [2:0] exp_17;
    logic [2:0] exp_19;
    logic [2:0] exp_23;
    logic [2:0] exp_29;
    logic [2:0] exp_31;
    logic       has_large_factor;

    modport source (
        output valid, input ready,
        output exp_2, exp_3, exp_5, exp_7, exp_11, exp_13,
        output exp_17, exp_19, exp_23, exp_29, exp_31, has_large_factor
    );
    modport sink (
        input valid, output ready,
        input exp_2, exp_3, exp_5, exp_7, exp_11, exp_13,
        input exp_17, exp_19, exp_23, exp_29, exp_31, has_large_factor
    );
endinterface

// File: sv/spef_dp.sv
module spef_dp #(
    parameter int INPUT_WIDTH = spef_pkg::INPUT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  spef_pkg::t_dp_cmd                   i_cmd,
    input  logic [INPUT_WIDTH-1:0]              i_n_value,
    output spef_pkg::t_dp_status                o_status,
    output logic [spef_pkg::EXP_W-1:0]          o_exp [spef_pkg::PRIME_COUNT],
    output logic                                o_has_large_factor
);
    import spef_pkg::*;

    localparam int DIGITS = (INPUT_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W  = DIGITS * DIGIT_W;

    logic [INPUT_WIDTH-1:0] r_n;
    logic [PAD_W-1:0]       r_work;
    logic [PRIME_W-1:0]     r_rem;
    t_idx                   r_idx;
    logic [EXP_W-1:0]       r_exp     [PRIME_COUNT];
    logic [EXP_W-1:0]       r_res_exp [PRIME_COUNT];
    logic                   r_res_flag;

    logic [PRIME_W-1:0]     c_div;
    logic [DIGIT_W-1:0]     c_digit;
    logic [DIGIT_W-1:0]     c_quo;
    logic [PRIME_W-1:0]     c_rem;
    logic [PRIME_W:0]       c_t;

    // restoring division of one digit by the current prime
    always_comb begin
        c_div   = prime_of(r_idx);
        c_digit = r_work[PAD_W-1 -: DIGIT_W];
        c_rem   = r_rem;
        c_quo   = '0;
        c_t     = '0;
        for (int b = DIGIT_W - 1; b >= 0; b--) begin
            c_t = {c_rem, c_digit[b]};
            if (c_t >= {1'b0, c_div}) begin
                c_quo[b] = 1'b1;
                c_t      = c_t - {1'b0, c_div};
            end
            c_rem = c_t[PRIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_n_value;
            r_idx <= '0;
            for (int k = 0; k < PRIME_COUNT; k++) begin
                r_exp[k] <= '0;
            end
        end
        if (i_cmd.start_div) begin
            r_work <= PAD_W'(r_n);
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_work <= (r_work << DIGIT_W) | PAD_W'(c_quo);
            r_rem  <= c_rem;
        end
        if (i_cmd.commit) begin
            if (r_rem == '0) begin
                r_n <= r_work[INPUT_WIDTH-1:0];
                if (r_exp[r_idx] != exp_limit(r_idx)) begin
                    r_exp[r_idx] <= r_exp[r_idx] + EXP_W'(1);
                end
            end else if (r_idx != t_idx'(PRIME_COUNT - 1)) begin
                r_idx <= r_idx + t_idx'(1);
            end
        end
        if (i_cmd.publish) begin
            r_res_exp  <= r_exp;
            r_res_flag <= (r_n > INPUT_WIDTH'(1));
        end
    end

    assign o_status.n_zero     = (r_n == '0);
    assign o_status.divisible  = (r_rem == '0);
    assign o_status.last_prime = (r_idx == t_idx'(PRIME_COUNT - 1));
    assign o_exp               = r_res_exp;
    assign o_has_large_factor  = r_res_flag;

endmodule

// File: sv/spef_ctrl.sv
`include "small_prime_exponent_factorizer_core_macros.svh"

module spef_ctrl #(
    parameter int INPUT_WIDTH = spef_pkg::INPUT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  spef_pkg::t_dp_status i_status,
    output spef_pkg::t_dp_cmd    o_cmd
);
    import spef_pkg::*;

    localparam int DIGITS = (INPUT_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_CHECK,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_digit, n_digit;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_digit = r_digit;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_status.n_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_digit         = '0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_digit == CNT_W'(DIGITS - 1)) begin
                    n_state = S_CHECK;
                end else begin
                    n_digit = r_digit + CNT_W'(1);
                end
            end
            S_CHECK: begin
                o_cmd.commit = 1'b1;
                if (!i_status.divisible && i_status.last_prime) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_START;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_digit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_digit     <= n_digit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `SPEF_ASSERT_IMPL(a_publish_slot_free, i_clk, i_rst_n, o_cmd.publish, !r_out_valid || i_out_ready)
    `SPEF_ASSERT_NEXT(a_start_then_step, i_clk, i_rst_n, o_cmd.start_div, o_cmd.div_step)
    `SPEF_ASSERT_NEXT(a_publish_sets_valid, i_clk, i_rst_n, o_cmd.publish, o_out_valid)

endmodule

// File: sv/small_prime_exponent_factorizer_core.sv
// Each prime is tried in turn by a restoring division over D = ceil(INPUT_WIDTH / 8) digits
// (D = 4 at 31 bits); a zero input skips division and goes straight to the result.
// Throughput: one item at a time; the next input is taken once the result sits in the
// output register. The 8-bit-per-cycle restoring divider sets the pace.
// Reset: i_rst_n synchronous, active low; clears the controller and output valid.
module small_prime_exponent_factorizer_core #(
    parameter int INPUT_WIDTH = spef_pkg::INPUT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spef_in_if.sink    i_in,
    spef_out_if.source o_out
);
    import spef_pkg::*;

    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic [EXP_W-1:0] w_exp [PRIME_COUNT];
    logic             w_flag;

    spef_ctrl #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    spef_dp #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_cmd              (w_cmd),
        .i_n_value          (i_in.n_value),
        .o_status           (w_status),
        .o_exp              (w_exp),
        .o_has_large_factor (w_flag)
    );

    assign o_out.exp_2            = w_exp[0][4:0];
    assign o_out.exp_3            = w_exp[1][4:0];
    assign o_out.exp_5            = w_exp[2][3:0];
    assign o_out.exp_7            = w_exp[3][3:0];
    assign o_out.exp_11           = w_exp[4][3:0];
    assign o_out.exp_13           = w_exp[5][3:0];
    assign o_out.exp_17           = w_exp[6][2:0];
    assign o_out.exp_19           = w_exp[7][2:0];
    assign o_out.exp_23           = w_exp[8][2:0];
    assign o_out.exp_29           = w_exp[9][2:0];
    assign o_out.exp_31           = w_exp[10][2:0];
    assign o_out.has_large_factor = w_flag;

endmodule

// File: tb/small_prime_exponent_factorizer_core_checker.sv
module small_prime_exponent_factorizer_core_checker #(
    parameter int INPUT_WIDTH = spef_pkg::INPUT_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spef_in_if   i_in_mon,
    spef_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import spef_pkg::*;

    typedef struct packed {
        logic [4:0] exp_2;
        logic [4:0] exp_3;
        logic [3:0] exp_5;
        logic [3:0] exp_7;
        logic [3:0] exp_11;
        logic [3:0] exp_13;
        logic [2:0] exp_17;
        logic [2:0] exp_19;
        logic [2:0] exp_23;
        logic [2:0] exp_29;
        logic [2:0] exp_31;
        logic       has_large_factor;
    } t_factor_result;

    typedef struct {
        logic [INPUT_WIDTH-1:0] operand;
        t_factor_result         want;
    } t_awaited_factorization;

    t_awaited_factorization awaited_factorizations [$];
    int fail_count    = 0;
    int pending_count = 0;

    assign o_fail_count    = fail_count;
    assign o_pending_count = pending_count;

    function automatic t_factor_result factor_small_primes(input logic [INPUT_WIDTH-1:0] n_in);
        int unsigned       small_primes [PRIME_COUNT] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
        int unsigned       field_width [PRIME_COUNT]  = '{5, 5, 4, 4, 4, 4, 3, 3, 3, 3, 3};
        int unsigned       exps [PRIME_COUNT];
        longint unsigned   rest;
        longint unsigned   count;
        longint unsigned   cap;
        t_factor_result    r;
        rest = longint'(n_in);
        for (int k = 0; k < PRIME_COUNT; k++) begin
            count = 0;
            if (rest != 0) begin
                while (rest % small_primes[k] == 0) begin
                    rest  = rest / small_primes[k];
                    count = count + 1;
                end
            end
            cap     = (64'd1 << field_width[k]) - 1;
            exps[k] = (count > cap) ? int'(cap) : int'(count);
        end
        r.exp_2            = 5'(exps[0]);
        r.exp_3            = 5'(exps[1]);
        r.exp_5            = 4'(exps[2]);
        r.exp_7            = 4'(exps[3]);
        r.exp_11           = 4'(exps[4]);
        r.exp_13           = 4'(exps[5]);
        r.exp_17           = 3'(exps[6]);
        r.exp_19           = 3'(exps[7]);
        r.exp_23           = 3'(exps[8]);
        r.exp_29           = 3'(exps[9]);
        r.exp_31           = 3'(exps[10]);
        r.has_large_factor = (rest > 1);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [INPUT_WIDTH-1:0] operand,
                                 input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: n=%0d %s expected %0d, actual %0d", $time, operand, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_awaited_factorization head;
        if (i_rst_n) begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (awaited_factorizations.size() == 0) begin
                    $display("%0t: result transfer with no input outstanding, expected none, actual exp_2=%0d",
                             $time, i_out_mon.exp_2);
                    fail_count++;
                end else begin
                    head = awaited_factorizations.pop_front();
                    compare_field("exp_2", head.operand, head.want.exp_2, i_out_mon.exp_2);
                    compare_field("exp_3", head.operand, head.want.exp_3, i_out_mon.exp_3);
                    compare_field("exp_5", head.operand, head.want.exp_5, i_out_mon.exp_5);
                    compare_field("exp_7", head.operand, head.want.exp_7, i_out_mon.exp_7);
                    compare_field("exp_11", head.operand, head.want.exp_11, i_out_mon.exp_11);
                    compare_field("exp_13", head.operand, head.want.exp_13, i_out_mon.exp_13);
                    compare_field("exp_17", head.operand, head.want.exp_17, i_out_mon.exp_17);
                    compare_field("exp_19", head.operand, head.want.exp_19, i_out_mon.exp_19);
                    compare_field("exp_23", head.operand, head.want.exp_23, i_out_mon.exp_23);
                    compare_field("exp_29", head.operand, head.want.exp_29, i_out_mon.exp_29);
                    compare_field("exp_31", head.operand, head.want.exp_31, i_out_mon.exp_31);
                    compare_field("has_large_factor", head.operand, head.want.has_large_factor,
                                  i_out_mon.has_large_factor);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                head.operand = i_in_mon.n_value;
                head.want    = factor_small_primes(i_in_mon.n_value);
                awaited_factorizations = {awaited_factorizations, head};
            end
            pending_count = awaited_factorizations.size();
        end
    end

endmodule

// File: tb/small_prime_exponent_factorizer_core_tb.sv
module small_prime_exponent_factorizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spef_pkg::*;

    localparam int              NW           = INPUT_WIDTH_DEF;
    localparam longint unsigned OPERAND_MAX  = (64'd1 << NW) - 1;
    localparam int              RANDOM_ITEMS = 690;
    localparam int              QUIET_TAIL   = 80;
    localparam int              LONG_HOLD    = 400;
    localparam int              HOLD_AFTER   = 40;
    localparam int              STALL_LIMIT  = 4000;
    localparam int              DRAIN_CYCLES = 300;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   quiet_tail = 1'b0;
    int   fail_count;
    int   pending_count;
    int   idle_cycles = 0;

    int unsigned corner_operands [$] = '{
        0, 1, 2, 3, 37, 961, 1184, 1073741824, 1162261467, 1220703125, 1977326743,
        214358881, 815730721, 410338673, 893871739, 148035889, 594823321, 887503681,
        2147483647, 2147483646, 223092870, 1431655765, 715827882, 1073741823, 1610612736
    };

    spef_in_if #(.INPUT_WIDTH(NW)) in_ch ();
    spef_out_if                    out_ch ();

    small_prime_exponent_factorizer_core #(.INPUT_WIDTH(NW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    small_prime_exponent_factorizer_core_checker #(.INPUT_WIDTH(NW)) u_factor_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // mostly products of small primes, some with a large cofactor, the rest raw bits
    function automatic logic [NW-1:0] random_operand();
        int unsigned     small_primes [PRIME_COUNT] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
        int unsigned     pick;
        int unsigned     p;
        longint unsigned v;
        longint unsigned cofactor;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return NW'($urandom >> $urandom_range(0, 31));
        end
        v = 1;
        repeat ($urandom_range(1, 40)) begin
            p = small_primes[$urandom_range(0, $urandom_range(0, PRIME_COUNT - 1))];
            if (v * p <= OPERAND_MAX) begin
                v = v * p;
            end
        end
        if (pick >= 7) begin
            cofactor = $urandom_range(37, 60000);
            if (v * cofactor <= OPERAND_MAX) begin
                v = v * cofactor;
            end
        end
        return NW'(v);
    endfunction

    task automatic send_operand(input logic [NW-1:0] v);
        in_ch.valid   <= 1'b1;
        in_ch.n_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.n_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (corner_operands[k]) begin
            send_operand(NW'(corner_operands[k]));
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k >= RANDOM_ITEMS - QUIET_TAIL) begin
                quiet_tail = 1'b1;
            end
            send_operand(random_operand());
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hold off once for a long stretch so the result register fills and input stalls
    initial begin
        int  n_taken;
        bit  hold_done;
        int  stretch;
        n_taken   = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!hold_done && n_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                stretch = $urandom_range(1, 24);
                repeat (stretch) begin
                    @(posedge i_clk);
                    if (out_ch.valid && out_ch.ready) begin
                        n_taken++;
                    end
                end
            end
        end
    end

endmodule
